/* sv/rgbc_pkg.sv */
// ----------------------------------------------------------------------------
// rgbc_pkg
// shared types, constants and arithmetic helpers of the 3x3 rgb convolution
// ----------------------------------------------------------------------------
package rgbc_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MIN_WIDTH   = 3;
  localparam int unsigned PTR_W       = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_W     = 11;
  localparam int unsigned COEFF_BITS  = 13;
  localparam int unsigned KREG_W      = 3 * COEFF_BITS;
  localparam int unsigned POS_W       = 24;
  localparam int unsigned PIX_W       = 24;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned SCALE_SHIFT = 8;

  // product of an unsigned channel and a signed coefficient
  localparam int unsigned PROD_W = COEFF_BITS + CH_W + 1;
  // one scaled tap keeps below the coefficient's magnitude
  localparam int unsigned TAP_W  = COEFF_BITS;
  // nine taps summed
  localparam int unsigned SUM_W  = TAP_W + 4;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // 32 in all three coefficient slots
  localparam logic [KREG_W-1:0] KERNEL_RESET =
    {COEFF_BITS'(32), COEFF_BITS'(32), COEFF_BITS'(32)};
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_LEFT  = 3'd0,
    CFG_KERNEL_MID   = 3'd1,
    CFG_KERNEL_RIGHT = 3'd2,
    CFG_LINE_WIDTH   = 3'd3
  } cfg_index_e;

  typedef logic [PIX_W-1:0] pixel_t;
  // window [dy][dx], dx = 2 is the newest column
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;
  // kernel registers indexed by dx
  typedef logic [2:0][KREG_W-1:0] kernel_set_t;
  typedef logic signed [TAP_W-1:0] tap_t;

  typedef struct packed {
    logic    vld;
    window_t win;
  } mac_req_t;

  // channel * coeff / 256, truncated toward zero
  function automatic tap_t scaled_tap(logic [CH_W-1:0] ch,
                                      logic signed [COEFF_BITS-1:0] c);
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] q;
    p    = $signed({1'b0, ch}) * c;
    bias = p[PROD_W-1] ? PROD_W'((1 << SCALE_SHIFT) - 1) : '0;
    q    = (p + bias) >>> SCALE_SHIFT;
    return q[TAP_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] clamp8(logic signed [SUM_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (v > $signed(SUM_W'((1 << CH_W) - 1))) begin
      r = '1;
    end else begin
      r = v[CH_W-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/rgbc_mac.sv */
// ----------------------------------------------------------------------------
// rgbc_mac
// scaled taps of the 3x3 window, then per-channel sum and clamp
// ----------------------------------------------------------------------------
module rgbc_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rgbc_pkg::mac_req_t    req_i,
  input  rgbc_pkg::kernel_set_t kern_i,
  output logic                  res_vld_o,
  output rgbc_pkg::pixel_t      res_o
);

  // [channel][dy][dx]
  rgbc_pkg::tap_t tap_q [3][3][3];
  logic           tap_vld_q;

  logic signed [rgbc_pkg::SUM_W-1:0] sum [3];

  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      for (int c = 0; c < 3; c++) begin
        for (int dy = 0; dy < 3; dy++) begin
          for (int dx = 0; dx < 3; dx++) begin
            tap_q[c][dy][dx] <= rgbc_pkg::scaled_tap(
              req_i.win[dy][dx][(2-c)*rgbc_pkg::CH_W +: rgbc_pkg::CH_W],
              $signed(kern_i[dx][dy*rgbc_pkg::COEFF_BITS +: rgbc_pkg::COEFF_BITS]));
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q <= 1'b0;
    end else begin
      tap_vld_q <= req_i.vld;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = '0;
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          sum[c] = sum[c] + rgbc_pkg::SUM_W'(tap_q[c][dy][dx]);
        end
      end
      res_o[(2-c)*rgbc_pkg::CH_W +: rgbc_pkg::CH_W] = rgbc_pkg::clamp8(sum[c]);
    end
  end

  assign res_vld_o = tap_vld_q;

endmodule

/* sv/rgbc_out_fifo.sv */
// ----------------------------------------------------------------------------
// rgbc_out_fifo
// small result queue that decouples the pipeline from output stalls
// ----------------------------------------------------------------------------
module rgbc_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rgbc_pkg::pixel_t push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output rgbc_pkg::pixel_t data_o
);

  rgbc_pkg::pixel_t                     mem_q [rgbc_pkg::FIFO_DEPTH];
  logic [rgbc_pkg::FIFO_PTR_W-1:0]      wr_ptr_q;
  logic [rgbc_pkg::FIFO_PTR_W-1:0]      rd_ptr_q;
  logic [rgbc_pkg::FIFO_CNT_W-1:0]      cnt_q;
  logic                                 pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* sv/rgb_convolution_3x3_core.sv */
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_core
// 3x3 convolution over a raster stream of 24-bit rgb pixels
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while ready and returns the filtered pixel
// of the position line_width+1 beats back, once line_width+2 beats of the
// frame have arrived; pad beats (kind = 1) count as black pixels and flush
// the end of a frame. Neighbors use flat addressing, so side taps at row
// edges come from the adjacent row. Every tap is channel * coeff / 256
// truncated toward zero, the nine taps of a channel are summed and clamped to
// 0..255. Sustained rate is one beat per clock while input ready holds; the
// path is set by the two line stores (one read and one write port each) and
// a four-stage pipeline: line-store read, window shift, tap multiply,
// sum/clamp into an eight-entry result queue. An accepted beat passes the
// stage-1 registers, the tap window, the tap registers and the result queue
// before its result shows on the output.
// Input ready drops only when eight results are already owed downstream.
// The line stores need no clearing after reset; reads of rows that do not
// exist yet are masked by the frame position.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rgbc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [rgbc_pkg::KREG_W-1:0]           cfg_data_i,
  // pixel input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  kind_i,
  input  logic                                  frame_start_i,
  input  logic [rgbc_pkg::PIX_W-1:0]            pixel_in_i,
  // filtered output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rgbc_pkg::PIX_W-1:0]            pixel_out_o
);

  // configuration registers
  rgbc_pkg::kernel_set_t                kern_q;
  logic [rgbc_pkg::WIDTH_W-1:0]         line_width_q;

  // frame position and line-store pointer
  logic [rgbc_pkg::POS_W-1:0]           pos_q;
  logic [rgbc_pkg::PTR_W-1:0]           ptr_q;

  // results owed downstream: in flight plus queued
  logic [rgbc_pkg::FIFO_CNT_W-1:0]      owed_q;

  // line stores, no reset: masked by position until written
  rgbc_pkg::pixel_t                     lower_mem [rgbc_pkg::MAX_WIDTH];
  rgbc_pkg::pixel_t                     upper_mem [rgbc_pkg::MAX_WIDTH];
  rgbc_pkg::pixel_t                     lower_rd_q;
  rgbc_pkg::pixel_t                     upper_rd_q;

  // stage 1: beat whose line-store reads are in flight
  logic                                 s1_vld_q;
  logic                                 s1_fs_q;
  logic                                 s1_use1_q;
  logic                                 s1_use2_q;
  logic                                 s1_emit_q;
  logic [rgbc_pkg::PTR_W-1:0]           s1_ptr_q;
  rgbc_pkg::pixel_t                     s1_x_q;

  // stage 2: tap window
  rgbc_pkg::window_t                    win_q;
  logic                                 win_vld_q;

  // accept-stage signals
  logic                                 in_acc;
  logic                                 out_pop;
  logic [rgbc_pkg::WIDTH_W-1:0]         w_eff;
  logic [rgbc_pkg::POS_W-1:0]           pos_base;
  logic [rgbc_pkg::POS_W-1:0]           pos_nxt;
  logic [rgbc_pkg::PTR_W-1:0]           ptr_base;
  logic [rgbc_pkg::PTR_W-1:0]           ptr_cur;
  logic [rgbc_pkg::WIDTH_W-1:0]         ptr_inc;
  logic [rgbc_pkg::PTR_W-1:0]           ptr_nxt;
  logic                                 use1;
  logic                                 use2;
  logic                                 emit;
  rgbc_pkg::pixel_t                     x_in;

  // stage-1 outputs
  rgbc_pkg::pixel_t                     d1;
  rgbc_pkg::pixel_t                     d2;

  rgbc_pkg::mac_req_t                   mac_req;
  logic                                 res_vld;
  rgbc_pkg::pixel_t                     res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (owed_q < rgbc_pkg::FIFO_CNT_W'(rgbc_pkg::FIFO_DEPTH));
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_pop     = out_valid_o && out_ready_i;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q       <= {3{rgbc_pkg::KERNEL_RESET}};
      line_width_q <= rgbc_pkg::WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rgbc_pkg::CFG_KERNEL_LEFT:  kern_q[0]    <= cfg_data_i;
        rgbc_pkg::CFG_KERNEL_MID:   kern_q[1]    <= cfg_data_i;
        rgbc_pkg::CFG_KERNEL_RIGHT: kern_q[2]    <= cfg_data_i;
        rgbc_pkg::CFG_LINE_WIDTH:   line_width_q <= cfg_data_i[rgbc_pkg::WIDTH_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // accept stage: position, pointer and line-store masking
  // ---------------------------------------------------------------------------
  always_comb begin
    // width clamped to 3..1024; the top bound is the line-store depth
    if (line_width_q < rgbc_pkg::WIDTH_W'(rgbc_pkg::MIN_WIDTH)) begin
      w_eff = rgbc_pkg::WIDTH_W'(rgbc_pkg::MIN_WIDTH);
    end else if (line_width_q > rgbc_pkg::WIDTH_W'(rgbc_pkg::MAX_WIDTH)) begin
      w_eff = rgbc_pkg::WIDTH_W'(rgbc_pkg::MAX_WIDTH);
    end else begin
      w_eff = line_width_q;
    end

    x_in     = kind_i ? '0 : pixel_in_i;
    pos_base = frame_start_i ? '0 : pos_q;
    ptr_base = frame_start_i ? '0 : ptr_q;

    // pointer may sit past a narrower width
    ptr_cur = ({1'b0, ptr_base} >= w_eff) ? '0 : ptr_base;
    ptr_inc = {1'b0, ptr_cur} + 1'b1;
    ptr_nxt = (ptr_inc >= w_eff) ? '0 : ptr_inc[rgbc_pkg::PTR_W-1:0];

    // rows that exist in this frame
    use1 = (pos_base >= rgbc_pkg::POS_W'(w_eff));
    use2 = (pos_base >= rgbc_pkg::POS_W'({w_eff, 1'b0}));

    // position saturates
    pos_nxt = (pos_base != rgbc_pkg::POS_MAX) ? pos_base + 1'b1 : pos_base;
    emit    = (pos_nxt >= rgbc_pkg::POS_W'(w_eff) + rgbc_pkg::POS_W'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ptr_q <= '0;
    end else if (in_acc) begin
      pos_q <= pos_nxt;
      ptr_q <= ptr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: lower holds the stream one row back, upper two rows back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lower_rd_q         <= lower_mem[ptr_cur];
      upper_rd_q         <= upper_mem[ptr_cur];
      lower_mem[ptr_cur] <= x_in;
    end
    // upper takes the masked row-one pixel in the cycle after the lower write
    if (s1_vld_q) begin
      upper_mem[s1_ptr_q] <= d1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_fs_q   <= frame_start_i;
      s1_use1_q <= use1;
      s1_use2_q <= use2;
      s1_emit_q <= emit;
      s1_ptr_q  <= ptr_cur;
      s1_x_q    <= x_in;
    end
  end

  assign d1 = s1_use1_q ? lower_rd_q : '0;
  assign d2 = s1_use2_q ? upper_rd_q : '0;

  // ---------------------------------------------------------------------------
  // tap window: shift left, new column on the right
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      win_vld_q <= 1'b0;
    end else begin
      win_vld_q <= s1_vld_q && s1_emit_q;
      if (s1_vld_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= s1_fs_q ? '0 : win_q[r][1];
          win_q[r][1] <= s1_fs_q ? '0 : win_q[r][2];
        end
        win_q[0][2] <= d2;
        win_q[1][2] <= d1;
        win_q[2][2] <= s1_x_q;
      end
    end
  end

  assign mac_req.vld = win_vld_q;
  assign mac_req.win = win_q;

  rgbc_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mac_req),
    .kern_i    (kern_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  rgbc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (pixel_out_o)
  );

  // ---------------------------------------------------------------------------
  // credit count keeps the queue from overflowing
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      if ((in_acc && emit) && !out_pop) begin
        owed_q <= owed_q + 1'b1;
      end else if (!(in_acc && emit) && out_pop) begin
        owed_q <= owed_q - 1'b1;
      end
    end
  end

endmodule

/* sv/rgbc_checker.sv */
// ----------------------------------------------------------------------------
// rgbc_checker
// port-level checks of the convolution core, bound to the top level
// ----------------------------------------------------------------------------
module rgbc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [rgbc_pkg::PIX_W-1:0] pixel_out_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o))
    else $error("result beat dropped or changed while stalled");

  // input is throttled only when results are waiting
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // a result appearing on an empty output follows an accepted input beat
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 4))
    else $error("result appeared without a matching input beat");

endmodule

bind rgb_convolution_3x3_core rgbc_checker u_rgbc_checker (.*);
